// ===== src/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the stuffed frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

   // Input beat kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Frame bytes
   localparam logic [7:0] START_BYTE  = 8'h10;
   localparam logic [7:0] TERM_BYTE   = 8'h0D;
   localparam logic [7:0] ESC_BYTE    = 8'h40;
   localparam logic [7:0] ESC_OF_ESC  = 8'h00;
   localparam logic [7:0] ESC_OF_TERM = 8'hCD;

   // Job queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Register file
   localparam int             CSR_ADDR_W     = 3;
   localparam int             CSR_DATA_W     = 32;
   localparam logic [0:0]     REG_STUFF_EN   = 1'b0;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // One fully resolved item: one or two output bytes
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;
      logic       term;
   } job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

// ===== src/sfb_front.sv =====
// ----------------------------------------------------------------------------
// sfb_front
// Accepts input beats, resolves escaping and the checksum, pushes jobs.
// ----------------------------------------------------------------------------
module sfb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stuff_enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sfb_pkg::req_type      req,
   input  sfb_pkg::q_status_type q_status,
   output logic                  push,
   output sfb_pkg::job_type      job
);
   import sfb_pkg::*;

   logic [7:0] running_sum_ff;
   logic [7:0] running_sum_in;
   logic       accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      job            = '0;
      push           = 1'b0;
      running_sum_in = running_sum_ff;
      case (req.kind)
         KIND_START: begin
            job.byte0      = START_BYTE;
            job.byte1      = req.value;
            job.two        = 1'b1;
            push           = accept;
            running_sum_in = START_BYTE + req.value;
         end
         KIND_DATA: begin
            push = accept;
            if (stuff_enable && req.value == ESC_BYTE) begin
               job.byte0      = ESC_BYTE;
               job.byte1      = ESC_OF_ESC;
               job.two        = 1'b1;
               running_sum_in = running_sum_ff + ESC_BYTE + ESC_OF_ESC;
            end else if (stuff_enable && req.value == TERM_BYTE) begin
               job.byte0      = ESC_BYTE;
               job.byte1      = ESC_OF_TERM;
               job.two        = 1'b1;
               running_sum_in = running_sum_ff + ESC_BYTE + ESC_OF_TERM;
            end else begin
               job.byte0      = req.value;
               running_sum_in = running_sum_ff + req.value;
            end
         end
         KIND_END: begin
            job.byte0      = 8'd0 - running_sum_ff;
            job.byte1      = TERM_BYTE;
            job.two        = 1'b1;
            job.term       = 1'b1;
            push           = accept;
            running_sum_in = '0;
         end
         default: begin
            // unused kind: consumed, no output, state kept
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
      end else if (accept) begin
         running_sum_ff <= running_sum_in;
      end
   end

endmodule

// ===== src/sfb_queue.sv =====
// ----------------------------------------------------------------------------
// sfb_queue
// Small job FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module sfb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sfb_pkg::job_type      push_job,
   input  logic                  pop,
   output sfb_pkg::job_type      head_job,
   output sfb_pkg::q_status_type q_status
);
   import sfb_pkg::*;

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff;
   logic [QUEUE_PTR_W:0]     count_in;
   logic                     do_push;
   logic                     do_pop;

   assign q_status.full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && q_status.valid;
   assign head_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/sfb_back.sv =====
// ----------------------------------------------------------------------------
// sfb_back
// Serializes queued jobs into output bytes through an output register.
// ----------------------------------------------------------------------------
module sfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sfb_pkg::q_status_type q_status,
   input  sfb_pkg::job_type      head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfb_pkg::rsp_type      rsp
);
   import sfb_pkg::*;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       pending_ff;
   logic [7:0] byte1_ff;
   logic       term_ff;
   logic       load;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign pop       = load && !pending_ff && q_status.valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else if (load) begin
         if (pending_ff) begin
            rsp_valid_ff <= 1'b1;
            pending_ff   <= 1'b0;
         end else if (q_status.valid) begin
            rsp_valid_ff <= 1'b1;
            pending_ff   <= head_job.two;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (pending_ff) begin
            rsp_ff.out_byte  <= byte1_ff;
            rsp_ff.run_last  <= 1'b1;
            rsp_ff.frame_end <= term_ff;
         end else if (q_status.valid) begin
            rsp_ff.out_byte  <= head_job.byte0;
            rsp_ff.run_last  <= !head_job.two;
            rsp_ff.frame_end <= 1'b0;
            byte1_ff         <= head_job.byte1;
            term_ff          <= head_job.term;
         end
      end
   end

endmodule

// ===== src/stuffed_frame_builder_top.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_builder_top
// Byte-stuffing serial framer with additive checksum.
// ----------------------------------------------------------------------------
// Path: the front pushes a job into the queue when the input beat is accepted,
//   and the back then loads the job's first byte into the output register.
// Throughput: one output byte per cycle from the back serializer unless
//   rsp_ready stalls it; start, escaped data and end items give two bytes.
//   Input beats are taken every cycle while the 4-entry job queue has room.
// Reset: running sum cleared, stuff_enable set to 1, queue and output empty.
// ----------------------------------------------------------------------------
module stuffed_frame_builder_top (
   input  logic                               clock,
   input  logic                               reset,
   // input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  sfb_pkg::req_type                   req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output sfb_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sfb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sfb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sfb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import sfb_pkg::*;

   logic         stuff_enable_ff;
   logic         csr_write;
   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;

   // Register port: one word, byte address 0 (bit 2 selects the word).
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_STUFF_EN) ?
                       {{(CSR_DATA_W-1){1'b0}}, stuff_enable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stuff_enable_ff <= 1'b1;
      end else if (csr_write && csr_paddr[2] == REG_STUFF_EN) begin
         stuff_enable_ff <= csr_pwdata[0];
      end
   end

   // Front: classify the beat, escape, track the sum, build the job.
   sfb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .stuff_enable (stuff_enable_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req_data),
      .q_status     (q_status),
      .push         (push),
      .job          (push_job)
   );

   // Decoupling queue of resolved jobs.
   sfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // Back: one byte per beat into the output register.
   sfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

   // A terminator beat closes its item and carries the terminator byte.
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |->
         rsp_data.run_last && rsp_data.out_byte == TERM_BYTE)
      else $error("frame_end beat is not a final terminator");

   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("job pushed into full queue");

   // The back only pops when a job is queued.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("job popped from empty queue");

   // Output is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

endmodule

// ===== tb/sv/tb_stuffed_frame_builder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_builder_top
// Self-checking bench for the byte-stuffing frame builder. Request beats come
// from a queue through a valid/ready driver. A frame model predicts every
// output byte, its escape, and the closing checksum. A monitor compares each
// result beat field by field. The stuffing register is set over the CSR port
// between idle phases. The run has a directed part and then random frames.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_builder_top;
   import sfb_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_PCT     = 24;
   localparam int HOLD_CYCLES  = 150;
   localparam logic [CSR_ADDR_W-1:0] STUFF_EN_ADDR = CSR_ADDR_W'(4 * REG_STUFF_EN);
   // Fourth request kind that the block should swallow
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // ---------------------------------------------------------------- signals
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ------------------------------------------------------- bench state
   req_type    pending_beats[$];        // request beats not yet offered
   rsp_type    expected_frame_bytes[$]; // predicted output bytes, oldest first
   rsp_type    oldest_due;
   logic [7:0] frame_sum;               // running checksum of the frame model
   logic       stuff_en_model;          // model copy of stuff_enable
   logic       no_idle       = 1'b0;    // set while one phase runs at full rate
   int         mismatch_count = 0;
   int         items_sent     = 0;
   int         beats_checked  = 0;
   int         frames_closed  = 0;
   int         escapes_seen   = 0;
   int         hold_left      = 0;
   int         next_hold_at   = 500;

   stuffed_frame_builder_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------- frame model
   // One predicted output byte; every emitted byte feeds the checksum.
   function automatic void emit_byte(logic [7:0] b, logic last, logic term);
      rsp_type r;
      r.out_byte  = b;
      r.run_last  = last;
      r.frame_end = term;
      frame_sum   = frame_sum + b;
      expected_frame_bytes.push_back(r);
   endfunction

   // Expected output bytes for one accepted request beat.
   function automatic void frame_model_step(req_type beat);
      logic [7:0] check;
      case (beat.kind)
         KIND_START: begin
            // A start inside a frame simply restarts the sum.
            frame_sum = 8'h00;
            emit_byte(START_BYTE, 1'b0, 1'b0);
            emit_byte(beat.value, 1'b1, 1'b0);   // command is never escaped
         end
         KIND_DATA: begin
            if (stuff_en_model && beat.value == ESC_BYTE) begin
               emit_byte(ESC_BYTE, 1'b0, 1'b0);
               emit_byte(ESC_OF_ESC, 1'b1, 1'b0);
               escapes_seen++;
            end else if (stuff_en_model && beat.value == TERM_BYTE) begin
               emit_byte(ESC_BYTE, 1'b0, 1'b0);
               emit_byte(ESC_OF_TERM, 1'b1, 1'b0);
               escapes_seen++;
            end else begin
               emit_byte(beat.value, 1'b1, 1'b0);
            end
         end
         KIND_END: begin
            // Works from whatever the sum holds, even with no start seen.
            check = 8'h00 - frame_sum;
            emit_byte(check, 1'b0, 1'b0);
            emit_byte(TERM_BYTE, 1'b1, 1'b1);
            frame_sum = 8'h00;
            frames_closed++;
         end
         default: ;   // unused kind: no bytes, state untouched
      endcase
   endfunction

   task automatic flag_mismatch(string what);
      $display("ERROR @%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------- request driver
   // Holds a beat until it is taken; next beat or a gap is chosen only when
   // the channel is free, so valid never drops without an accept.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            frame_model_step(req_data);
            if (req_data.kind != KIND_UNUSED) items_sent++;
         end
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 &&
                (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------- result sink
   // Random stalls, plus a long hold every thousand beats so the job queue
   // fills and backs up into the request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (beats_checked >= next_hold_at) begin
         hold_left    <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 1000;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frame_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat byte=%02h last=%0b end=%0b",
                                    rsp_data.out_byte, rsp_data.run_last,
                                    rsp_data.frame_end));
         end else begin
            oldest_due = expected_frame_bytes.pop_front();
            if (rsp_data.out_byte !== oldest_due.out_byte)
               flag_mismatch($sformatf("beat %0d out_byte %02h, want %02h",
                                       beats_checked, rsp_data.out_byte,
                                       oldest_due.out_byte));
            if (rsp_data.run_last !== oldest_due.run_last)
               flag_mismatch($sformatf("beat %0d run_last %0b, want %0b",
                                       beats_checked, rsp_data.run_last,
                                       oldest_due.run_last));
            if (rsp_data.frame_end !== oldest_due.frame_end)
               flag_mismatch($sformatf("beat %0d frame_end %0b, want %0b",
                                       beats_checked, rsp_data.frame_end,
                                       oldest_due.frame_end));
         end
         beats_checked++;
      end
   end

   // ------------------------------------------------------- stimulus helpers
   function automatic void queue_beat(logic [1:0] kind, logic [7:0] value);
      req_type b;
      b.kind  = kind;
      b.value = value;
      pending_beats.push_back(b);
   endfunction

   // Payload biased toward the two bytes that get escaped.
   function automatic logic [7:0] rand_payload();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return ESC_BYTE;
      if (roll < 40) return TERM_BYTE;
      return 8'($urandom);
   endfunction

   // CSR write with a setup and an access phase; the register takes it on the access edge.
   task automatic program_stuffing(logic en);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= STUFF_EN_ADDR;
      csr_pwdata  <= {31'($urandom), en};   // upper bits are don't-care
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      stuff_en_model = en;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Wait for the queue, the channel and the scoreboard to empty, then give
   // a swallowed beat time to clear the pipe before touching the register.
   task automatic settle();
      while (pending_beats.size() != 0 || req_valid ||
             expected_frame_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed frames; the rest is stray data, stray ends,
   // truncated frames and ignored beats.
   task automatic queue_random_traffic(int target);
      int made;
      int roll;
      int len;
      made = 0;
      while (made < target) begin
         roll = $urandom_range(99);
         if (roll < 85) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
            queue_beat(KIND_START, 8'($urandom));
            repeat (len) queue_beat(KIND_DATA, rand_payload());
            queue_beat(KIND_END, 8'($urandom));
            made += len + 2;
         end else if (roll < 89) begin
            queue_beat(KIND_UNUSED, 8'($urandom));
         end else if (roll < 93) begin
            queue_beat(KIND_DATA, rand_payload());
            made++;
         end else if (roll < 96) begin
            queue_beat(KIND_END, 8'($urandom));
            made++;
         end else begin
            // cut short: the next frame's start restarts it
            len = $urandom_range(4);
            queue_beat(KIND_START, 8'($urandom));
            repeat (len) queue_beat(KIND_DATA, rand_payload());
            made += len + 1;
         end
      end
   endtask

   // ------------------------------------------------------- main sequence
   initial begin
      frame_sum      = 8'h00;
      stuff_en_model = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, stuffing on: escapes, extremes, unescaped command,
      // ignored kind, data/end with no start, start inside a frame.
      program_stuffing(1'b1);
      queue_beat(KIND_START, 8'h00);
      queue_beat(KIND_DATA,  ESC_BYTE);
      queue_beat(KIND_DATA,  TERM_BYTE);
      queue_beat(KIND_DATA,  8'h00);
      queue_beat(KIND_DATA,  8'hFF);
      queue_beat(KIND_DATA,  START_BYTE);
      queue_beat(KIND_END,   8'hFF);
      queue_beat(KIND_START, ESC_BYTE);
      queue_beat(KIND_DATA,  ESC_OF_TERM);
      queue_beat(KIND_UNUSED, 8'hAA);
      queue_beat(KIND_DATA,  TERM_BYTE);
      queue_beat(KIND_END,   8'h00);
      queue_beat(KIND_DATA,  8'h55);
      queue_beat(KIND_END,   8'h55);
      queue_beat(KIND_END,   8'hAA);
      queue_beat(KIND_START, 8'h12);
      queue_beat(KIND_DATA,  8'h55);
      queue_beat(KIND_START, 8'hFF);
      queue_beat(KIND_DATA,  ESC_BYTE);
      queue_beat(KIND_END,   8'h3C);
      settle();

      // Directed, stuffing off: special bytes pass through untouched.
      program_stuffing(1'b0);
      queue_beat(KIND_START, TERM_BYTE);
      queue_beat(KIND_DATA,  ESC_BYTE);
      queue_beat(KIND_DATA,  TERM_BYTE);
      queue_beat(KIND_END,   8'hC3);
      settle();

      // Random phases, alternating the register; one runs with no idling.
      program_stuffing(1'b1);
      queue_random_traffic(260);
      settle();
      program_stuffing(1'b0);
      queue_random_traffic(260);
      settle();
      no_idle = 1'b1;
      program_stuffing(1'b1);
      queue_random_traffic(260);
      settle();
      no_idle = 1'b0;
      program_stuffing(1'b0);
      queue_random_traffic(260);
      settle();
      program_stuffing(1'b1);
      queue_random_traffic(260);
      settle();

      if (expected_frame_bytes.size() != 0)
         flag_mismatch($sformatf("%0d predicted bytes never came out",
                                 expected_frame_bytes.size()));

      $display("Covered %0d request items, %0d output bytes, %0d closed frames,",
               items_sent, beats_checked, frames_closed);
      $display("%0d escaped bytes, both stuffing modes, %0d mismatches.",
               escapes_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timed out waiting for the frame builder");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
